### sv/bbpq_pkg.sv
package bbpq_pkg;

  localparam int unsigned SLOTS     = 4096;
  localparam int unsigned LEVELS    = 256;
  localparam int unsigned SLOT_AW   = 12;
  localparam int unsigned LINK_W    = 13;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned ID_W      = 31;
  localparam int unsigned BKT_W     = 8;
  localparam int unsigned LOW_W     = 9;
  localparam int unsigned MAP_WORDS = 4;
  localparam int unsigned WORD_W    = 64;

  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(SLOTS);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(SLOTS);
  localparam logic [LOW_W-1:0]  NO_BUCKET  = LOW_W'(LEVELS);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_EVICTED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic             func;
    logic [ID_W-1:0]  entry_id;
    logic [BKT_W-1:0] bucket;
  } bbpq_in_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  popped_id;
    logic [CNT_W-1:0] occupancy;
    logic [LOW_W-1:0] lowest_bucket;
  } bbpq_out_t;

  typedef struct packed {
    logic [SLOT_AW-1:0] head;
    logic [SLOT_AW-1:0] tail;
  } hdtl_t;

  typedef struct packed {
    logic start;
    logic high;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [BKT_W-1:0] idx;
  } scan_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EV0,
    S_EV1,
    S_EV2,
    S_P0,
    S_P1,
    S_P2,
    S_HI,
    S_Q0,
    S_Q1,
    S_Q2,
    S_LO
  } state_e;

endpackage

### sv/bbpq_ram.sv
module bbpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/bbpq_scan.sv
module bbpq_scan (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  bbpq_pkg::scan_req_t                           req_i,
  input  logic [bbpq_pkg::LEVELS-1:0]                   map_i,
  output bbpq_pkg::scan_rsp_t                           rsp_o
);
  import bbpq_pkg::*;

  // two-level encoder: byte first, then bit within the byte
  function automatic logic [5:0] enc64(logic [WORD_W-1:0] v, logic high);
    logic [7:0] nz;
    logic [2:0] bi;
    logic [2:0] ki;
    logic [7:0] by;
    nz = '0;
    bi = '0;
    ki = '0;
    for (int i = 0; i < 8; i++) begin
      nz[i] = |v[i*8 +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      if (high) begin
        if (nz[i]) bi = 3'(i);
      end else begin
        if (nz[7-i]) bi = 3'(7 - i);
      end
    end
    by = v[bi*8 +: 8];
    for (int i = 0; i < 8; i++) begin
      if (high) begin
        if (by[i]) ki = 3'(i);
      end else begin
        if (by[7-i]) ki = 3'(7 - i);
      end
    end
    return {bi, ki};
  endfunction

  logic             busy_q;
  logic             high_q;
  logic [1:0]       wptr_q;
  logic [WORD_W-1:0] word;
  logic             last;
  logic             hit;

  assign word = map_i[wptr_q*WORD_W +: WORD_W];
  assign hit  = |word;
  assign last = high_q ? (wptr_q == 2'd0) : (wptr_q == 2'(MAP_WORDS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      high_q <= 1'b0;
      wptr_q <= '0;
    end else if (!busy_q) begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        high_q <= req_i.high;
        wptr_q <= req_i.high ? 2'(MAP_WORDS - 1) : 2'd0;
      end
    end else if (hit || last) begin
      busy_q <= 1'b0;
    end else begin
      wptr_q <= high_q ? wptr_q - 2'd1 : wptr_q + 2'd1;
    end
  end

  always_comb begin
    rsp_o.done  = busy_q && (hit || last);
    rsp_o.found = hit;
    rsp_o.idx   = {wptr_q, enc64(word, high_q)};
  end

endmodule

### sv/bounded_bucket_priority_queue_core.sv
// drop and pop-on-empty give their result in the cycle after the transfer; a push
// runs states P0, P1, P2, after EV0, EV1, EV2 when it evicts; a pop runs a
// highest bucket scan of 1 to 4 words, then Q0, Q1, Q2; emptying the lowest bucket
// adds a rescan. one item at a time: busy stays high until the result strobe.
// the receiver cannot stall: each result shows for exactly one cycle.
// reset clears control, occupancy map and counters; memories are not cleared.
module bounded_bucket_priority_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bbpq_pkg::bbpq_in_t  req_i,
  output logic                rsp_valid_o,
  output bbpq_pkg::bbpq_out_t rsp_o
);
  import bbpq_pkg::*;

  state_e state_q, state_d;

  // item being worked on
  bbpq_in_t             req_q, req_d;
  logic                 evict_q, evict_d;     // push evicted the lowest oldest
  logic                 lo_clr_q, lo_clr_d;   // lowest bucket went empty
  logic [SLOT_AW-1:0]   h_q, h_d;             // head slot read from a bucket
  logic [SLOT_AW-1:0]   t_q, t_d;             // tail slot read from a bucket
  logic [SLOT_AW-1:0]   slot_q, slot_d;       // slot taken for a push
  logic                 use_free_q, use_free_d;
  logic [BKT_W-1:0]     hi_q, hi_d;
  logic [ID_W-1:0]      popped_q, popped_d;

  // queue state kept in flops
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [LOW_W-1:0]     lowest_q, lowest_d;
  logic [LEVELS-1:0]    map_q, map_d;         // also valid bits of head/tail
  logic [LINK_W-1:0]    free_head_q, free_head_d;  // released slots
  logic [CNT_W-1:0]     water_q, water_d;     // slots never handed out start here

  logic                 emit;
  status_e              status_d;
  bbpq_out_t            rsp_q;
  logic                 rsp_valid_q;

  // memory ports
  logic                 id_we;
  logic [SLOT_AW-1:0]   id_waddr, id_raddr;
  logic [ID_W-1:0]      id_rdata;
  logic                 link_we;
  logic [SLOT_AW-1:0]   link_waddr, link_raddr;
  logic [LINK_W-1:0]    link_wdata, link_rdata;
  logic                 hdtl_we;
  logic [BKT_W-1:0]     hdtl_waddr, hdtl_raddr;
  hdtl_t                hdtl_wdata, hdtl_rdata;

  scan_req_t            scan_req;
  scan_rsp_t            scan_rsp;

  logic                 acc;
  logic                 is_pop;
  logic                 empty;
  logic                 full;
  logic                 drop;

  assign acc    = start && !busy;
  assign is_pop = (req_i.func == FUNC_POP);
  assign empty  = (cnt_q == '0);
  assign full   = (cnt_q == FULL_COUNT);
  // when full the lowest bucket always exists
  assign drop   = full && ({1'b0, req_i.bucket} <= lowest_q);

  bbpq_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (req_q.entry_id),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  bbpq_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  bbpq_ram #(.WIDTH($bits(hdtl_t)), .DEPTH(LEVELS)) u_hdtl_ram (
    .clk_i   (clk_i),
    .we_i    (hdtl_we),
    .waddr_i (hdtl_waddr),
    .wdata_i (hdtl_wdata),
    .raddr_i (hdtl_raddr),
    .rdata_o (hdtl_rdata)
  );

  bbpq_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .map_i  (map_q),
    .rsp_o  (scan_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (is_pop) begin
            state_d = empty ? S_IDLE : S_HI;
          end else if (!full) begin
            state_d = S_P0;
          end else begin
            state_d = drop ? S_IDLE : S_EV0;
          end
        end
      end
      S_EV0: state_d = S_EV1;
      S_EV1: state_d = S_EV2;
      S_EV2: state_d = S_P0;
      S_P0:  state_d = S_P1;
      S_P1:  state_d = S_P2;
      S_P2:  state_d = lo_clr_q ? S_LO : S_IDLE;
      S_HI: begin
        if (scan_rsp.done) state_d = S_Q0;
      end
      S_Q0:  state_d = S_Q1;
      S_Q1:  state_d = S_Q2;
      S_Q2: begin
        // popped bucket emptied and it was the lowest one: rescan
        if ((h_q == t_q) && ({1'b0, hi_q} == lowest_q)) state_d = S_LO;
        else state_d = S_IDLE;
      end
      S_LO: begin
        if (scan_rsp.done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    evict_d     = evict_q;
    lo_clr_d    = lo_clr_q;
    h_d         = h_q;
    t_d         = t_q;
    slot_d      = slot_q;
    use_free_d  = use_free_q;
    hi_d        = hi_q;
    popped_d    = popped_q;
    cnt_d       = cnt_q;
    lowest_d    = lowest_q;
    map_d       = map_q;
    free_head_d = free_head_q;
    water_d     = water_q;
    emit        = 1'b0;
    status_d    = ST_STORED;
    id_we       = 1'b0;
    id_waddr    = slot_q;
    id_raddr    = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = NULL_LINK;
    link_raddr  = '0;
    hdtl_we     = 1'b0;
    hdtl_waddr  = '0;
    hdtl_wdata  = '0;
    hdtl_raddr  = '0;
    scan_req    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          req_d    = req_i;
          evict_d  = 1'b0;
          lo_clr_d = 1'b0;
          popped_d = '0;
          if (is_pop) begin
            if (empty) begin
              emit     = 1'b1;
              status_d = ST_EMPTY;
            end else begin
              scan_req.start = 1'b1;
              scan_req.high  = 1'b1;
            end
          end else if (drop) begin
            emit     = 1'b1;
            status_d = ST_DROPPED;
          end
        end
      end
      // eviction of the oldest entry of the lowest bucket
      S_EV0: begin
        hdtl_raddr = lowest_q[BKT_W-1:0];
      end
      S_EV1: begin
        h_d        = hdtl_rdata.head;
        t_d        = hdtl_rdata.tail;
        link_raddr = hdtl_rdata.head;
      end
      S_EV2: begin
        hdtl_we         = 1'b1;
        hdtl_waddr      = lowest_q[BKT_W-1:0];
        hdtl_wdata.head = link_rdata[SLOT_AW-1:0];
        hdtl_wdata.tail = t_q;
        if (h_q == t_q) begin
          map_d[lowest_q[BKT_W-1:0]] = 1'b0;
          lo_clr_d = 1'b1;
        end
        link_we     = 1'b1;
        link_waddr  = h_q;
        link_wdata  = free_head_q;
        free_head_d = {1'b0, h_q};
        cnt_d       = cnt_q - CNT_W'(1);
        evict_d     = 1'b1;
      end
      // insertion at the tail of the pushed bucket
      S_P0: begin
        hdtl_raddr = req_q.bucket;
        if (free_head_q != NULL_LINK) begin
          slot_d     = free_head_q[SLOT_AW-1:0];
          link_raddr = free_head_q[SLOT_AW-1:0];
          use_free_d = 1'b1;
        end else begin
          slot_d     = water_q[SLOT_AW-1:0];
          water_d    = water_q + CNT_W'(1);
          use_free_d = 1'b0;
        end
        id_we    = 1'b1;
        id_waddr = slot_d;
      end
      S_P1: begin
        if (use_free_q) free_head_d = link_rdata;
        h_d        = hdtl_rdata.head;
        t_d        = hdtl_rdata.tail;
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = NULL_LINK;
      end
      S_P2: begin
        hdtl_we    = 1'b1;
        hdtl_waddr = req_q.bucket;
        if (map_q[req_q.bucket]) begin
          link_we         = 1'b1;
          link_waddr      = t_q;
          link_wdata      = {1'b0, slot_q};
          hdtl_wdata.head = h_q;
        end else begin
          hdtl_wdata.head = slot_q;
        end
        hdtl_wdata.tail = slot_q;
        map_d[req_q.bucket] = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
        if (lo_clr_q) begin
          scan_req.start = 1'b1;
          scan_req.high  = 1'b0;
        end else begin
          if ({1'b0, req_q.bucket} < lowest_q) lowest_d = {1'b0, req_q.bucket};
          emit     = 1'b1;
          status_d = evict_q ? ST_EVICTED : ST_STORED;
        end
      end
      // pop of the oldest entry of the highest bucket
      S_HI: begin
        if (scan_rsp.done) hi_d = scan_rsp.idx;
      end
      S_Q0: begin
        hdtl_raddr = hi_q;
      end
      S_Q1: begin
        h_d        = hdtl_rdata.head;
        t_d        = hdtl_rdata.tail;
        link_raddr = hdtl_rdata.head;
        id_raddr   = hdtl_rdata.head;
      end
      S_Q2: begin
        popped_d        = id_rdata;
        hdtl_we         = 1'b1;
        hdtl_waddr      = hi_q;
        hdtl_wdata.head = link_rdata[SLOT_AW-1:0];
        hdtl_wdata.tail = t_q;
        if (h_q == t_q) map_d[hi_q] = 1'b0;
        link_we     = 1'b1;
        link_waddr  = h_q;
        link_wdata  = free_head_q;
        free_head_d = {1'b0, h_q};
        cnt_d       = cnt_q - CNT_W'(1);
        if ((h_q == t_q) && ({1'b0, hi_q} == lowest_q)) begin
          scan_req.start = 1'b1;
          scan_req.high  = 1'b0;
        end else begin
          emit     = 1'b1;
          status_d = ST_POPPED;
        end
      end
      S_LO: begin
        if (scan_rsp.done) begin
          lowest_d = scan_rsp.found ? {1'b0, scan_rsp.idx} : NO_BUCKET;
          emit     = 1'b1;
          if (req_q.func == FUNC_POP) status_d = ST_POPPED;
          else status_d = evict_q ? ST_EVICTED : ST_STORED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lowest_q    <= NO_BUCKET;
      map_q       <= '0;
      free_head_q <= NULL_LINK;
      water_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lowest_q    <= lowest_d;
      map_q       <= map_d;
      free_head_q <= free_head_d;
      water_q     <= water_d;
      rsp_valid_q <= emit;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    evict_q    <= evict_d;
    lo_clr_q   <= lo_clr_d;
    h_q        <= h_d;
    t_q        <= t_d;
    slot_q     <= slot_d;
    use_free_q <= use_free_d;
    hi_q       <= hi_d;
    popped_q   <= popped_d;
    if (emit) begin
      rsp_q.status        <= status_d;
      rsp_q.popped_id     <= popped_d;
      rsp_q.occupancy     <= cnt_d;
      rsp_q.lowest_bucket <= lowest_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### sv/bbpq_checker.sv
module bbpq_props (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input bbpq_pkg::bbpq_in_t  req_i,
  input logic                rsp_valid_o,
  input bbpq_pkg::bbpq_out_t rsp_o
);
  import bbpq_pkg::*;

  // a result only ends an item, so the block is free while it shows
  a_rsp_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy) else $error("result while busy");

  // an accepted item is either answered at once or keeps the block busy
  a_acc_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_valid_o)) else $error("item lost");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without transfer");

  // an empty queue has no lowest bucket
  a_empty_lowest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.occupancy == '0)) |-> (rsp_o.lowest_bucket == NO_BUCKET))
    else $error("lowest bucket on empty queue");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ST_EMPTY)) |->
      (rsp_o.occupancy == '0 && rsp_o.popped_id == '0))
    else $error("pop on empty with stored entries");

endmodule

bind bounded_bucket_priority_queue_core bbpq_props u_bbpq_props (.*);
